// File: rtl/string_table_validate_select_unit_macros.svh
// assertion macros shared by the string table checker
// clocked on clk, disabled while rst_n is low
`ifndef STRING_TABLE_VALIDATE_SELECT_UNIT_MACROS_SVH
`define STRING_TABLE_VALIDATE_SELECT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define STVS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stvs assertion failed");

// next-cycle implication
`define STVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stvs assertion failed");

`else

`define STVS_ASSERT_SAME(lbl, ante, cons)
`define STVS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/stvs_pkg.sv
`default_nettype none

package stvs_pkg;

    // span size limit default
    localparam int unsigned MaxSpanDefault = 4096;

    // fnv-1a constants
    localparam logic [31:0] FnvBasis = 32'd2166136261;

    // configuration register indexes
    localparam logic [2:0] RegEntryCount    = 3'd0;
    localparam logic [2:0] RegSelectedIndex = 3'd1;
    localparam logic [2:0] RegExpectedHash  = 3'd2;
    localparam logic [2:0] RegSpanLength    = 3'd3;
    localparam logic [2:0] RegNameCapacity  = 3'd4;

    // configuration reset values
    localparam logic [11:0] EntryCountReset    = 12'd69;
    localparam logic [10:0] SelectedIndexReset = 11'd0;
    localparam logic [31:0] ExpectedHashReset  = 32'h1020AC88;
    localparam logic [12:0] SpanLengthReset    = 13'd4096;
    localparam logic [12:0] NameCapacityReset  = 13'd4096;

    // counter saturation value
    localparam logic [11:0] CountMax = 12'hFFF;

    // one byte of the span
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stvs_beat_t;

    // configuration seen by the span parser
    typedef struct packed {
        logic [11:0] entry_count;
        logic [10:0] selected_index;
        logic [12:0] span_length;
        logic [12:0] name_capacity;
    } stvs_cfg_t;

    // parser verdict for the byte being processed
    typedef struct packed {
        logic        format_ok;
        logic [11:0] offset;
        logic [11:0] length;
    } stvs_status_t;

    // multiply by the fnv prime 0x01000193 with shifts and adds, modulo 2^32
    function automatic logic [31:0] fnv_mul_prime(input logic [31:0] x);
        logic [31:0] acc;
        acc = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
        return acc;
    endfunction

endpackage

`default_nettype wire

// File: rtl/string_table_validate_select_unit.sv
// String table span checker. Bytes of one span enter one per transaction on the
// in channel, the final one flagged by last_byte; each byte is folded into a 32-bit
// FNV-1a hash and the span is split into zero-terminated entries. After the final
// byte one transaction leaves on the out channel: table_ok is set only when the hash,
// span length, entry count and the selected entry's length against name_capacity all
// check out, and name_offset / name_length then give the selected entry (both zero
// otherwise). One byte is taken every cycle while the input does not stall; each byte
// sits in the input register while its update (the hash multiply by the prime, done
// as shifts and adds) is computed combinationally, and the result register loads when
// a last byte leaves the input register. Only a last byte whose result register is still
// held by the consumer stalls the input. The user must write the configuration registers
// through cfg_we / cfg_index / cfg_data while no span is in flight; the block does not
// enforce this. Indexes above 4 are ignored.
`default_nettype none
`include "string_table_validate_select_unit_macros.svh"

module string_table_validate_select_unit
    import stvs_pkg::*;
#(
    parameter int unsigned MAX_SPAN = MaxSpanDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             table_ok,
    output logic [11:0]      name_offset,
    output logic [11:0]      name_length
);

    logic [11:0]  entry_count_reg;
    logic [10:0]  selected_index_reg;
    logic [31:0]  expected_hash_reg;
    logic [12:0]  span_length_reg;
    logic [12:0]  name_capacity_reg;

    logic         s1_valid_reg;
    stvs_beat_t   s1_beat_reg;

    logic         out_valid_reg;
    logic         table_ok_reg;
    logic [11:0]  name_offset_reg;
    logic [11:0]  name_length_reg;

    logic         out_free;
    logic         s1_fire;
    logic         hash_match;
    logic         result_ok;
    stvs_cfg_t    cfg;
    stvs_status_t status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg    <= EntryCountReset;
            selected_index_reg <= SelectedIndexReset;
            expected_hash_reg  <= ExpectedHashReset;
            span_length_reg    <= SpanLengthReset;
            name_capacity_reg  <= NameCapacityReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegEntryCount:    entry_count_reg    <= cfg_data[11:0];
                RegSelectedIndex: selected_index_reg <= cfg_data[10:0];
                RegExpectedHash:  expected_hash_reg  <= cfg_data;
                RegSpanLength:    span_length_reg    <= cfg_data[12:0];
                RegNameCapacity:  name_capacity_reg  <= cfg_data[12:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.entry_count    = entry_count_reg;
        cfg.selected_index = selected_index_reg;
        cfg.span_length    = span_length_reg;
        cfg.name_capacity  = name_capacity_reg;
    end

    // handshake: only a last byte needs room in the result register
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!s1_beat_reg.last || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_beat_reg.data <= data_byte;
            s1_beat_reg.last <= last_byte;
        end
    end

    // hash unit
    stvs_hash u_hash (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s1_fire),
        .beat          (s1_beat_reg),
        .expected_hash (expected_hash_reg),
        .hash_match    (hash_match)
    );

    // entry splitter and span checks
    stvs_parse #(
        .MAX_SPAN (MAX_SPAN)
    ) u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_fire),
        .beat   (s1_beat_reg),
        .cfg    (cfg),
        .status (status)
    );

    assign result_ok = hash_match && status.format_ok;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_beat_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_beat_reg.last)
        begin
            table_ok_reg    <= result_ok;
            name_offset_reg <= result_ok ? status.offset : 12'd0;
            name_length_reg <= result_ok ? status.length : 12'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign table_ok    = table_ok_reg;
    assign name_offset = name_offset_reg;
    assign name_length = name_length_reg;

    // a failed result carries no entry
    `STVS_ASSERT_SAME(a_fail_zero, out_valid_reg && !table_ok_reg,
        (name_offset_reg == 12'd0) && (name_length_reg == 12'd0))

    // the input stalls only behind a last byte waiting for the result register
    `STVS_ASSERT_SAME(a_stall_cause, !in_ready,
        s1_valid_reg && s1_beat_reg.last && out_valid_reg && !out_ready)

    // a new result follows a processed last byte
    `STVS_ASSERT_NEXT(a_result_source, s1_fire && s1_beat_reg.last, out_valid_reg)

endmodule

`default_nettype wire

// File: rtl/stvs_hash.sv
`default_nettype none

module stvs_hash
    import stvs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire stvs_beat_t  beat,
    input  wire logic [31:0] expected_hash,
    output logic             hash_match
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;

    // fold in the byte: xor then multiply by the prime
    always_comb
    begin
        hash_next = fnv_mul_prime(hash_reg ^ {24'd0, beat.data});
    end

    assign hash_match = (hash_next == expected_hash);

    // running hash, back to the basis after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FnvBasis;
        end
        else if (step)
        begin
            hash_reg <= beat.last ? FnvBasis : hash_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/stvs_parse.sv
`default_nettype none

module stvs_parse
    import stvs_pkg::*;
#(
    parameter int unsigned MAX_SPAN = MaxSpanDefault
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire stvs_beat_t   beat,
    input  wire stvs_cfg_t    cfg,
    output stvs_status_t      status
);

    localparam int unsigned PW = $clog2(MAX_SPAN + 1);
    localparam int unsigned EW = (PW > 13) ? PW : 13;

    logic [PW-1:0] pos_reg, pos_next;
    logic [11:0]   entries_reg, entries_next;
    logic [11:0]   cur_len_reg, cur_len_next;
    logic [11:0]   start_reg, start_next;
    logic [11:0]   chosen_off_reg, chosen_off_next;
    logic [11:0]   chosen_len_reg, chosen_len_next;
    logic          ferr_reg, ferr_next;

    logic          overflow;
    logic          is_zero;
    logic [EW-1:0] pos_inc;

    // per-byte update of the entry splitter
    always_comb
    begin
        overflow        = (pos_reg == PW'(MAX_SPAN));
        is_zero         = (beat.data == 8'd0);
        pos_inc         = EW'(pos_reg) + EW'(1);
        ferr_next       = ferr_reg | overflow | (is_zero & (cur_len_reg == 12'd0));
        entries_next    = entries_reg;
        cur_len_next    = cur_len_reg;
        start_next      = start_reg;
        chosen_off_next = chosen_off_reg;
        chosen_len_next = chosen_len_reg;
        if (is_zero)
        begin
            if ((cur_len_reg != 12'd0) && (entries_reg == {1'b0, cfg.selected_index}))
            begin
                chosen_off_next = start_reg;
                chosen_len_next = cur_len_reg;
            end
            if (entries_reg != CountMax)
            begin
                entries_next = entries_reg + 12'd1;
            end
            start_next   = pos_inc[11:0];
            cur_len_next = 12'd0;
        end
        else if (cur_len_reg != CountMax)
        begin
            cur_len_next = cur_len_reg + 12'd1;
        end
        pos_next = overflow ? pos_reg : pos_inc[PW-1:0];
    end

    // span checks on the updated state
    always_comb
    begin
        status.format_ok = (EW'(pos_next) == EW'(cfg.span_length))
                         && !ferr_next
                         && (entries_next == cfg.entry_count)
                         && (cur_len_next == 12'd0)
                         && ({1'b0, cfg.selected_index} < cfg.entry_count)
                         && (cfg.name_capacity != 13'd0)
                         && ({1'b0, chosen_len_next} <= cfg.name_capacity);
        status.offset    = chosen_off_next;
        status.length    = chosen_len_next;
    end

    // span state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            entries_reg    <= '0;
            cur_len_reg    <= '0;
            start_reg      <= '0;
            chosen_off_reg <= '0;
            chosen_len_reg <= '0;
            ferr_reg       <= 1'b0;
        end
        else if (step)
        begin
            if (beat.last)
            begin
                pos_reg        <= '0;
                entries_reg    <= '0;
                cur_len_reg    <= '0;
                start_reg      <= '0;
                chosen_off_reg <= '0;
                chosen_len_reg <= '0;
                ferr_reg       <= 1'b0;
            end
            else
            begin
                pos_reg        <= pos_next;
                entries_reg    <= entries_next;
                cur_len_reg    <= cur_len_next;
                start_reg      <= start_next;
                chosen_off_reg <= chosen_off_next;
                chosen_len_reg <= chosen_len_next;
                ferr_reg       <= ferr_next;
            end
        end
    end

endmodule

`default_nettype wire
